FILE: rtl/core/jmsp_pkg.sv
`timescale 1ns / 1ps
// jmsp_pkg: beat types, scan phase constants and the marker classifier
// shared by the marker scanner. No dependencies.
package jmsp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } jmsp_in_t;

  typedef struct packed {
    logic [7:0] precision;
    logic       status;
  } jmsp_out_t;

  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PhaseEmpty = 3'd0;
  localparam logic [PhaseW-1:0] PhaseFull  = 3'd4;
  localparam logic [PhaseW-1:0] PhaseDone  = 3'd5;
  localparam logic [PhaseW-1:0] WindowLen  = 3'd5;

  localparam logic [7:0]  MarkerPrefix = 8'hFF;
  localparam logic [15:0] MinSkipLen   = 16'd3;
  localparam logic        StatusFound  = 1'b0;
  localparam logic        StatusNone   = 1'b1;

  typedef enum logic [2:0] {
    KindInvalid = 3'd0,
    KindSof     = 3'd1,
    KindSegment = 3'd2,
    KindFixed   = 3'd3,
    KindFill    = 3'd4
  } marker_kind_e;

  function automatic marker_kind_e classify_marker(logic [7:0] hi, logic [7:0] lo);
    marker_kind_e kind;
    kind = KindInvalid;
    if (hi == MarkerPrefix) begin
      unique case (lo) inside
        8'hC4, 8'hC8, 8'hCC: kind = KindSegment;
        [8'hC0:8'hC3], [8'hC5:8'hC7], [8'hC9:8'hCB], [8'hCD:8'hCF]: kind = KindSof;
        [8'hD0:8'hD9]: kind = KindFixed;
        [8'hDA:8'hFE]: kind = KindSegment;
        8'hFF: kind = KindFill;
        8'h01, [8'h03:8'hBF]: kind = KindFixed;
        default: kind = KindInvalid;
      endcase
    end
    return kind;
  endfunction

endpackage

FILE: rtl/core/jmsp_in_reg.sv
`timescale 1ns / 1ps
// jmsp_in_reg: input register that holds one byte beat until the scanner
// takes it. Depends on jmsp_pkg.
module jmsp_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  jmsp_pkg::jmsp_in_t in_data_i,
  input  logic             take_i,
  output logic             beat_valid_o,
  output jmsp_pkg::jmsp_in_t beat_o
);
  import jmsp_pkg::*;

  logic     valid_q, valid_d;
  jmsp_in_t beat_q;
  logic     load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= in_data_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

endmodule

FILE: rtl/core/jmsp_scan.sv
`timescale 1ns / 1ps
// jmsp_scan: marker window, skip counter and result register; consumes one
// beat per cycle unless a held result is stalled. Depends on jmsp_pkg.
module jmsp_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_valid_i,
  input  jmsp_pkg::jmsp_in_t beat_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output jmsp_pkg::jmsp_out_t out_data_o
);
  import jmsp_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [7:0]        win_q [4];
  logic [7:0]        win_d [4];
  logic [15:0]       skip_q, skip_d;
  logic              out_valid_q, out_valid_d;
  jmsp_out_t         out_q, res_d;
  logic              res_load;
  logic              take;

  assign take   = beat_valid_i && (!out_valid_q || !out_stall_i);
  assign take_o = take;

  always_comb begin
    marker_kind_e kind;
    logic [15:0]  seglen;
    logic [2:0]   adv;
    logic [2:0]   idx;
    logic         shift;
    logic [7:0]   full_win [5];

    kind   = classify_marker(win_q[0], win_q[1]);
    seglen = {win_q[2], win_q[3]};
    adv    = 3'd0;
    idx    = 3'd0;
    shift  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      full_win[i] = win_q[i];
    end
    full_win[4] = beat_i.byte_value;

    phase_d  = phase_q;
    skip_d   = skip_q;
    win_d    = win_q;
    res_load = 1'b0;
    res_d    = out_q;

    if (take) begin
      if (phase_q != PhaseDone) begin
        if (skip_q != 16'd0) begin
          skip_d = skip_q - 16'd1;
        end else if (phase_q < PhaseFull) begin
          win_d[phase_q[1:0]] = beat_i.byte_value;
          phase_d = phase_q + 3'd1;
        end else begin
          case (kind)
            KindSof: begin
              res_load = 1'b1;
              res_d    = '{precision: beat_i.byte_value, status: StatusFound};
              phase_d  = PhaseDone;
            end
            KindFill: begin
              adv   = 3'd1;
              shift = 1'b1;
            end
            KindFixed: begin
              adv   = 3'd2;
              shift = 1'b1;
            end
            KindSegment: begin
              if (seglen >= MinSkipLen) begin
                phase_d = PhaseEmpty;
                skip_d  = seglen - MinSkipLen;
              end else begin
                adv   = seglen[2:0] + 3'd2;
                shift = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
              res_d    = '{precision: 8'd0, status: StatusNone};
              phase_d  = PhaseDone;
            end
          endcase
          if (shift) begin
            for (int i = 0; i < 4; i++) begin
              idx = adv + 3'(i);
              win_d[i] = (idx < WindowLen) ? full_win[idx] : 8'd0;
            end
            phase_d = WindowLen - adv;
          end
        end
      end
      if (beat_i.last_byte) begin
        if (!res_load && phase_d != PhaseDone) begin
          res_load = 1'b1;
          res_d    = '{precision: 8'd0, status: StatusNone};
        end
        phase_d = PhaseEmpty;
        skip_d  = 16'd0;
        for (int i = 0; i < 4; i++) begin
          win_d[i] = 8'd0;
        end
      end
    end
  end

  assign out_valid_d = res_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhaseEmpty;
      skip_q      <= 16'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        win_q[i] <= 8'd0;
      end
    end else begin
      phase_q     <= phase_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !(out_valid_q && out_stall_i))
    else $error("beat taken while result register full and stalled");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhaseDone)
    else $error("scan phase out of range");

  a_skip_only_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q != 16'd0 |-> phase_q == PhaseEmpty)
    else $error("skip pending with partial window");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && beat_i.last_byte |=> phase_q == PhaseEmpty && skip_q == 16'd0)
    else $error("scan not cleared after last byte");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && phase_q == PhaseDone |-> !res_load)
    else $error("second result in one stream");

  a_last_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && beat_i.last_byte && phase_q != PhaseDone |=> out_valid_q)
    else $error("stream ended without a result");

endmodule

FILE: rtl/core/jpeg_marker_scan_precision_core.sv
`timescale 1ns / 1ps
// A beat accepted into the input register is scanned from there; its result, if any,
// is offered from the result register. Throughput: one byte beat per cycle while
// the held result is not stalled; one result per stream at most.
// Reset (async, active low) empties both registers and restarts the scan at a marker.
// Depends on jmsp_pkg, jmsp_in_reg, jmsp_scan.
module jpeg_marker_scan_precision_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jmsp_pkg::jmsp_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jmsp_pkg::jmsp_out_t out_data_o
);
  import jmsp_pkg::*;

  logic     beat_valid;
  jmsp_in_t beat;
  logic     take;

  jmsp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .take_i       (take),
    .beat_valid_o (beat_valid),
    .beat_o       (beat)
  );

  jmsp_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_i       (beat),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
